// ===== src/tcas_pkg.sv =====
// Shared constants for the two-channel converter smoother.
package tcas_pkg;

  localparam int ACC_BITS   = 16;
  localparam int PHASE_BITS = 8;
  localparam int MUX_BITS   = 4;

  localparam logic [PHASE_BITS-1:0] SETTLE_MASK       = 8'h7C;
  localparam int                    TEMP_PHASE_BIT    = 7;
  localparam logic [PHASE_BITS-1:0] VOLT_READY_PHASE  = 8'd64;
  localparam logic [PHASE_BITS-1:0] TEMP_READY_PHASE  = 8'd192;
  localparam logic [PHASE_BITS-1:0] TEMP_SWITCH_PHASE = 8'd128;
  localparam logic [PHASE_BITS-1:0] VOLT_SWITCH_PHASE = 8'd0;

  localparam logic [MUX_BITS-1:0] MUX_REFERENCE   = 4'd14;
  localparam logic [MUX_BITS-1:0] MUX_TEMPERATURE = 4'd1;

endpackage

// ===== src/tcas_in_if.sv =====
// Sample channel: valid, ready and one converter sample.
interface tcas_in_if #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== src/tcas_out_if.sv =====
// Result channel: valid, ready and the smoothed channel status.
interface tcas_out_if import tcas_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [MUX_BITS-1:0]    mux_channel;
  logic                   mux_changed;
  logic [SAMPLE_BITS-1:0] voltage_avg;
  logic [SAMPLE_BITS-1:0] temperature_avg;
  logic                   voltage_ready;
  logic                   temperature_ready;
  logic                   sample_used;

  modport source (
    output valid, output mux_channel, output mux_changed, output voltage_avg,
    output temperature_avg, output voltage_ready, output temperature_ready,
    output sample_used, input ready
  );
  modport sink (
    input valid, input mux_channel, input mux_changed, input voltage_avg,
    input temperature_avg, input voltage_ready, input temperature_ready,
    input sample_used, output ready
  );
endinterface

// ===== src/two_channel_adc_smoother_unit.sv =====
// Two-channel converter smoother: phase sequencing, averaging and result register.
//
//   channel  direction  payload
//   in_ch    sink       sample
//   out_ch   source     mux_channel, mux_changed, averages, ready flags, sample_used
//
// The phase step and one accumulator add-subtract for each sample beat are combinational
// from the state registers; the updated state is registered on acceptance and is the result.
// A new sample is taken in every cycle while the result register is empty or drained.
// Reset clears the phase, accumulators, held averages and flags, and selects the
// reference input. A stalled result holds its beat and stops further samples.
module two_channel_adc_smoother_unit import tcas_pkg::*; #(
  parameter int SMOOTH_SHIFT = 5,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  tcas_in_if.sink     in_ch,
  tcas_out_if.source  out_ch
);

  logic [PHASE_BITS-1:0]  phase_r, phase_nxt;
  logic [ACC_BITS-1:0]    volt_acc_r, volt_acc_nxt;
  logic [ACC_BITS-1:0]    temp_acc_r, temp_acc_nxt;
  logic [SAMPLE_BITS-1:0] volt_hold_r, volt_hold_nxt;
  logic [SAMPLE_BITS-1:0] temp_hold_r, temp_hold_nxt;
  logic                   volt_flag_r, volt_flag_nxt;
  logic                   temp_flag_r, temp_flag_nxt;
  logic [MUX_BITS-1:0]    mux_r, mux_nxt;
  logic                   used_nxt;

  logic                   out_valid_r;
  logic                   out_changed_r;
  logic                   out_used_r;

  logic                   in_acc;
  logic                   temp_sel;
  logic [ACC_BITS-1:0]    acc_sel;
  logic [ACC_BITS-1:0]    avg;
  logic [ACC_BITS-1:0]    acc_upd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign phase_nxt = phase_r + 1'b1;
  assign temp_sel  = phase_nxt[TEMP_PHASE_BIT];
  assign acc_sel   = temp_sel ? temp_acc_r : volt_acc_r;
  assign avg       = acc_sel >> SMOOTH_SHIFT;
  assign acc_upd   = acc_sel + ACC_BITS'(in_ch.sample) - avg;

  always_comb begin
    volt_acc_nxt  = volt_acc_r;
    temp_acc_nxt  = temp_acc_r;
    volt_hold_nxt = volt_hold_r;
    temp_hold_nxt = temp_hold_r;
    volt_flag_nxt = volt_flag_r;
    temp_flag_nxt = temp_flag_r;
    mux_nxt       = mux_r;
    used_nxt      = 1'b0;
    if ((phase_nxt & SETTLE_MASK) != '0) begin
      used_nxt = 1'b1;
      if (temp_sel) begin
        temp_acc_nxt  = acc_upd;
        temp_hold_nxt = avg[SAMPLE_BITS-1:0];
        if (phase_nxt == TEMP_READY_PHASE) begin
          temp_flag_nxt = 1'b1;
        end
      end else begin
        volt_acc_nxt  = acc_upd;
        volt_hold_nxt = avg[SAMPLE_BITS-1:0];
        if (phase_nxt == VOLT_READY_PHASE) begin
          volt_flag_nxt = 1'b1;
        end
      end
    end else if (phase_nxt == TEMP_SWITCH_PHASE) begin
      mux_nxt = MUX_TEMPERATURE;
    end else if (phase_nxt == VOLT_SWITCH_PHASE) begin
      mux_nxt = MUX_REFERENCE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      volt_acc_r  <= '0;
      temp_acc_r  <= '0;
      volt_hold_r <= '0;
      temp_hold_r <= '0;
      volt_flag_r <= 1'b0;
      temp_flag_r <= 1'b0;
      mux_r       <= MUX_REFERENCE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        volt_acc_r  <= volt_acc_nxt;
        temp_acc_r  <= temp_acc_nxt;
        volt_hold_r <= volt_hold_nxt;
        temp_hold_r <= temp_hold_nxt;
        volt_flag_r <= volt_flag_nxt;
        temp_flag_r <= temp_flag_nxt;
        mux_r       <= mux_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_changed_r <= (mux_nxt != mux_r);
      out_used_r    <= used_nxt;
    end
  end

  // The held state is exactly the state after the last accepted beat.
  assign out_ch.valid             = out_valid_r;
  assign out_ch.mux_channel       = mux_r;
  assign out_ch.mux_changed       = out_changed_r;
  assign out_ch.voltage_avg       = volt_hold_r;
  assign out_ch.temperature_avg   = temp_hold_r;
  assign out_ch.voltage_ready     = volt_flag_r;
  assign out_ch.temperature_ready = temp_flag_r;
  assign out_ch.sample_used       = out_used_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted sample beat produced no result");

  a_switch_not_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_changed_r && out_used_r))
    else $error("multiplexer switched on a used sample");

  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (volt_flag_r || temp_flag_r) |=>
      ((volt_flag_r || !$past(volt_flag_r)) && (temp_flag_r || !$past(temp_flag_r))))
    else $error("ready flag cleared after being set");

  a_mux_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (mux_r == MUX_REFERENCE) || (mux_r == MUX_TEMPERATURE))
    else $error("multiplexer selection holds an unknown input");

endmodule

// ===== dv/tcas_smoother_checker.sv =====
// Watches the sample and result channels, predicts each result and compares it.
module tcas_smoother_checker import tcas_pkg::*; #(
  parameter int SMOOTH_SHIFT = 5,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic clk,
  input  logic rst_n,
  tcas_in_if   in_mon,
  tcas_out_if  out_mon,
  output int   errors,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    logic [MUX_BITS-1:0]    mux_channel;
    logic                   mux_changed;
    logic [SAMPLE_BITS-1:0] voltage_avg;
    logic [SAMPLE_BITS-1:0] temperature_avg;
    logic                   voltage_ready;
    logic                   temperature_ready;
    logic                   sample_used;
  } channel_status_t;

  channel_status_t status_q[$];

  logic [PHASE_BITS-1:0]  phase_r;
  logic [ACC_BITS-1:0]    volt_acc;
  logic [ACC_BITS-1:0]    temp_acc;
  logic [SAMPLE_BITS-1:0] volt_hold;
  logic [SAMPLE_BITS-1:0] temp_hold;
  logic                   volt_flag;
  logic                   temp_flag;
  logic [MUX_BITS-1:0]    mux_sel;

  function automatic channel_status_t next_status(input logic [SAMPLE_BITS-1:0] s);
    channel_status_t     st;
    logic [ACC_BITS-1:0] avg;
    logic [MUX_BITS-1:0] prev_mux;
    prev_mux       = mux_sel;
    st.sample_used = 1'b0;
    phase_r        = phase_r + 1'b1;
    if ((phase_r & SETTLE_MASK) != '0) begin
      st.sample_used = 1'b1;
      if (phase_r[TEMP_PHASE_BIT]) begin
        avg       = temp_acc >> SMOOTH_SHIFT;
        temp_acc  = temp_acc + ACC_BITS'(s) - avg;
        temp_hold = avg[SAMPLE_BITS-1:0];
        if (phase_r == TEMP_READY_PHASE) temp_flag = 1'b1;
      end else begin
        avg       = volt_acc >> SMOOTH_SHIFT;
        volt_acc  = volt_acc + ACC_BITS'(s) - avg;
        volt_hold = avg[SAMPLE_BITS-1:0];
        if (phase_r == VOLT_READY_PHASE) volt_flag = 1'b1;
      end
    end else if (phase_r == TEMP_SWITCH_PHASE) begin
      mux_sel = MUX_TEMPERATURE;
    end else if (phase_r == VOLT_SWITCH_PHASE) begin
      mux_sel = MUX_REFERENCE;
    end
    st.mux_channel       = mux_sel;
    st.mux_changed       = (mux_sel != prev_mux);
    st.voltage_avg       = volt_hold;
    st.temperature_avg   = temp_hold;
    st.voltage_ready     = volt_flag;
    st.temperature_ready = temp_flag;
    return st;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (actv !== expv) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin : watch
    channel_status_t want;
    if (!rst_n) begin
      phase_r   = '0;
      volt_acc  = '0;
      temp_acc  = '0;
      volt_hold = '0;
      temp_hold = '0;
      volt_flag = 1'b0;
      temp_flag = 1'b0;
      mux_sel   = MUX_REFERENCE;
      status_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) status_q.push_back(next_status(in_mon.sample));
      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: result beat arrived with no sample waiting for it", $time);
        end else begin
          want = status_q.pop_front();
          checked++;
          check_field("mux_channel", 16'(want.mux_channel), 16'(out_mon.mux_channel));
          check_field("mux_changed", 16'(want.mux_changed), 16'(out_mon.mux_changed));
          check_field("voltage_avg", 16'(want.voltage_avg), 16'(out_mon.voltage_avg));
          check_field("temperature_avg", 16'(want.temperature_avg),
                      16'(out_mon.temperature_avg));
          check_field("voltage_ready", 16'(want.voltage_ready), 16'(out_mon.voltage_ready));
          check_field("temperature_ready", 16'(want.temperature_ready),
                      16'(out_mon.temperature_ready));
          check_field("sample_used", 16'(want.sample_used), 16'(out_mon.sample_used));
        end
      end
    end
    pending = status_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top of the smoother testbench: clock, reset, sample and stall stimulus, verdict.
module tb;

  localparam int SAMPLE_BITS    = 10;
  localparam int RANDOM_SAMPLES = 1600;
  localparam int IDLE_LIMIT     = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 4;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   checked;
  int   samples_sent;
  int   hold_requests;
  int   holds_done;
  int   idle_cycles;

  tcas_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  tcas_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  two_channel_adc_smoother_unit #(.SMOOTH_SHIFT(5), .SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tcas_smoother_checker #(.SMOOTH_SHIFT(5), .SAMPLE_BITS(SAMPLE_BITS)) smoother_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] shape_sample(input int mode, input int level);
    int v;
    case (mode)
      0:       v = $urandom_range(0, 1023);
      1:       v = level + $urandom_range(0, 15) - 7;
      2:       v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
      default: v = level;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_BITS'(v);
  endfunction

  // The receiver stalls on a pattern of its own and honours long hold-off requests.
  initial begin
    int mode;
    int left;
    int hold_left;
    out_ch.ready = 1'b0;
    mode         = 0;
    left         = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_channel_adc_smoother_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SAMPLE_BITS-1:0] directed[24];
    int                     total;
    int                     burst_len;
    int                     mode;
    int                     level;
    int                     next_hold;
    bit                     paused;
    directed = '{10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h2AA, 10'h155, 10'h001, 10'h200,
                 10'h3FF, 10'h3FF, 10'h3FE, 10'h000, 10'h1FF, 10'h100, 10'h080, 10'h040,
                 10'h020, 10'h010, 10'h008, 10'h004, 10'h002, 10'h3FF, 10'h000, 10'h3FF};
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    rst_n        = 1'b0;
    next_hold    = 400;
    paused       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      send_sample(directed[i]);
      if (i % 5 == 4) idle_gap(1 + i % 3);
    end
    wait_drained();

    total = samples_sent + RANDOM_SAMPLES;
    while (samples_sent < total) begin
      if (samples_sent >= next_hold && hold_requests < 2) begin
        hold_requests++;
        next_hold = next_hold + 700;
      end
      if (!paused && samples_sent >= 900) begin
        wait_drained();
        paused = 1'b1;
      end
      burst_len = $urandom_range(1, 24);
      mode      = $urandom_range(0, 3);
      level     = $urandom_range(0, 1023);
      repeat (burst_len) send_sample(shape_sample(mode, level));
      if (!(samples_sent >= 1000 && samples_sent < 1150) && $urandom_range(0, 3) != 0)
        idle_gap($urandom_range(1, 8));
    end
    wait_drained();

    $display("Sent %0d samples over %0d full phase cycles; %0d result beats checked.",
             samples_sent, samples_sent / 256, checked);
    $display("Receiver held off %0d times for %0d cycles; sender drained once mid-run.",
             holds_done, HOLD_CYCLES);
    if (errors == 0) begin
      $display("two_channel_adc_smoother_unit: match");
    end else begin
      $display("two_channel_adc_smoother_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tcas_pkg.sv
src/tcas_in_if.sv
src/tcas_out_if.sv
src/two_channel_adc_smoother_unit.sv
dv/tcas_smoother_checker.sv
dv/tb.sv
